// ===== rtl/core/pwm_duty_soft_ramp_top_defines.svh =====
// assertion macros for the pwm duty soft ramp block
`ifndef PWM_DUTY_SOFT_RAMP_TOP_DEFINES_SVH
`define PWM_DUTY_SOFT_RAMP_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define PSR_ASSERT_IMPL(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("pwm ramp check failed");
`define PSR_ASSERT_ALWAYS(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("pwm ramp check failed");
`else
`define PSR_ASSERT_IMPL(name, pre, post)
`define PSR_ASSERT_ALWAYS(name, cond)
`endif

`endif

// ===== rtl/core/psr_pkg.sv =====
// shared types, constants and helpers of the pwm duty soft ramp block
package psr_pkg;

	localparam int DUTY_FULL = 4095;
	localparam int MAX_STEP  = 1023;

	localparam int DUTY_W     = 13;
	localparam int DRIVE_W    = 14;
	localparam int TIME_W     = 32;
	localparam int DELAY_W    = 10;
	localparam int CUST_W     = 22;
	localparam int PRESET_W   = 3;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 22;

	localparam int STEP_W = $clog2(MAX_STEP + 1);
	localparam int FULL_W = $clog2(DUTY_FULL + 1);
	localparam int PROD_W = FULL_W + TIME_W;
	localparam int CNT_W  = $clog2(STEP_W + 1);
	localparam int SUM_W  = ((DUTY_W > STEP_W) ? DUTY_W : STEP_W) + 2;

	localparam int S_DATA_W = ((DUTY_W + TIME_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((DRIVE_W + DUTY_W + DELAY_W + 7) / 8) * 8;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIDIR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRESET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CUSTOM = 3'd4;

	localparam logic [PRESET_W-1:0] PRE_SHORT  = 3'd1;
	localparam logic [PRESET_W-1:0] PRE_MID    = 3'd2;
	localparam logic [PRESET_W-1:0] PRE_LONG   = 3'd3;
	localparam logic [PRESET_W-1:0] PRE_CUSTOM = 3'd4;

	localparam logic [CUST_W-1:0] T_SHORT = CUST_W'(250);
	localparam logic [CUST_W-1:0] T_MID   = CUST_W'(750);
	localparam logic [CUST_W-1:0] T_LONG  = CUST_W'(2000);

	localparam logic [DELAY_W-1:0] DELAY_ACTIVE = DELAY_W'(10);
	localparam logic [DELAY_W-1:0] DELAY_IDLE   = DELAY_W'(1000);

	localparam logic signed [DUTY_W-1:0] DUTY_MAX    = DUTY_W'(DUTY_FULL);
	localparam logic signed [DUTY_W-1:0] DUTY_MIN_BI = DUTY_W'(-DUTY_FULL);

	typedef struct packed {
		logic                enable;
		logic                invert;
		logic                bidirectional;
		logic [PRESET_W-1:0] preset;
		logic [CUST_W-1:0]   custom_ms;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic signed [DUTY_W-1:0] duty;
		logic [TIME_W-1:0]        now_ms;
	} job_t;

	function automatic logic [CUST_W-1:0] transition_ms(input cfg_t c);
		logic [CUST_W-1:0] t;
		case (c.preset)
			PRE_SHORT:  t = T_SHORT;
			PRE_MID:    t = T_MID;
			PRE_LONG:   t = T_LONG;
			PRE_CUSTOM: t = c.custom_ms;
			default:    t = '0;
		endcase
		return t;
	endfunction

	function automatic logic signed [DUTY_W-1:0] min_duty(input logic bidir);
		return bidir ? DUTY_MIN_BI : '0;
	endfunction

endpackage

// ===== rtl/core/psr_front.sv =====
// input side: decodes commands and clamps set requests before queueing
module psr_front
	import psr_pkg::*;
(
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,  // request_duty, now_ms
	input  logic [CMD_W-1:0]    s_axis_tuser,  // cmd
	input  cfg_t                cfg,
	input  logic                q_full,
	output logic                push,
	output job_t                job
);

	logic signed [DUTY_W-1:0] req;
	logic signed [DUTY_W-1:0] lo;
	logic signed [DUTY_W-1:0] clamped;
	logic                     known;

	assign req = s_axis_tdata[DUTY_W-1:0];
	assign lo  = min_duty(cfg.bidirectional);

	always_comb begin
		if (req < lo) begin
			clamped = lo;
		end else if (req > DUTY_MAX) begin
			clamped = DUTY_MAX;
		end else begin
			clamped = req;
		end
	end

	assign known = (s_axis_tuser == CMD_SET) || (s_axis_tuser == CMD_CLEAR) ||
		(s_axis_tuser == CMD_TICK);

	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full && known;

	assign job.cmd    = s_axis_tuser;
	assign job.duty   = clamped;
	assign job.now_ms = s_axis_tdata[DUTY_W +: TIME_W];

endmodule

// ===== rtl/core/psr_queue.sv =====
// short fifo between the input side and the ramp engine
module psr_queue
	import psr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t job_in,
	output logic full,
	input  logic pop,
	output logic valid,
	output job_t job_out
);

	job_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full    = count_q == (QPTR_W + 1)'(QDEPTH);
	assign valid   = count_q != '0;
	assign job_out = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/psr_back.sv =====
// ramp engine: request state, iterative step divide, result register
module psr_back
	import psr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                cfg_drop,
	input  logic                q_valid,
	input  job_t                q_job,
	output logic                q_pop,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [M_DATA_W-1:0] m_axis_tdata,  // drive_value, actual_duty, next_delay_ms
	output logic [0:0]          m_axis_tuser   // drive_valid
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_SAT   = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_APPLY = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0]                state_q;
	logic signed [DUTY_W-1:0]  held_q;
	logic                      present_q;
	logic signed [DUTY_W-1:0]  ramp_q;
	logic [TIME_W-1:0]         last_q;
	logic                      out_valid_q;

	logic [CUST_W-1:0]         t_q;
	logic signed [DUTY_W-1:0]  desired_q;
	logic [TIME_W-1:0]         now_q;
	logic [TIME_W-1:0]         elapsed_q;
	logic [PROD_W-1:0]         prod_q;
	logic [PROD_W-1:0]         dsh_q;
	logic [STEP_W-1:0]         quo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [STEP_W-1:0]         inc_q;
	logic                      res_valid_q;
	logic signed [DRIVE_W-1:0] res_drive_q;
	logic signed [DUTY_W-1:0]  res_actual_q;
	logic [DELAY_W-1:0]        res_delay_q;
	logic [M_DATA_W-1:0]       out_data_q;
	logic                      out_user_q;

	logic [CUST_W-1:0]         t_now;
	logic signed [DUTY_W-1:0]  desired_now;
	logic                      ge;
	logic [STEP_W-1:0]         quo_next;
	logic signed [SUM_W-1:0]   r_s;
	logic signed [SUM_W-1:0]   d_s;
	logic signed [SUM_W-1:0]   i_s;
	logic signed [SUM_W-1:0]   up_s;
	logic signed [SUM_W-1:0]   dn_s;
	logic signed [SUM_W-1:0]   nxt_s;
	logic signed [DUTY_W-1:0]  ramp_next;
	logic                      load_out;

	function automatic logic signed [DRIVE_W-1:0] drive_of(
		input logic signed [DUTY_W-1:0] duty,
		input logic                     inv
	);
		logic signed [DRIVE_W-1:0] ext;
		ext = DRIVE_W'(duty);
		return inv ? (DRIVE_W'(DUTY_FULL) - ext) : ext;
	endfunction

	assign t_now       = transition_ms(cfg);
	assign desired_now = present_q ? held_q : '0;
	assign q_pop       = (state_q == ST_IDLE) && q_valid;
	assign load_out    = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

	assign ge       = prod_q >= dsh_q;
	assign quo_next = STEP_W'({quo_q, ge});

	always_comb begin
		r_s  = SUM_W'(ramp_q);
		d_s  = SUM_W'(desired_q);
		i_s  = SUM_W'(inc_q);
		up_s = r_s + i_s;
		dn_s = r_s - i_s;
		if (r_s < d_s) begin
			nxt_s = (up_s > d_s) ? d_s : up_s;
		end else if (r_s > d_s) begin
			nxt_s = (dn_s < d_s) ? d_s : dn_s;
		end else begin
			nxt_s = r_s;
		end
		if ((d_s > 0) && (nxt_s == '0)) begin
			nxt_s = SUM_W'(1);
		end
		ramp_next = DUTY_W'(nxt_s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			held_q      <= '0;
			present_q   <= 1'b0;
			ramp_q      <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_drop) begin
				held_q    <= '0;
				present_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						case (q_job.cmd)
							CMD_SET: begin
								held_q    <= q_job.duty;
								present_q <= 1'b1;
							end
							CMD_CLEAR: begin
								if (present_q) begin
									held_q    <= '0;
									present_q <= 1'b0;
									state_q   <= ST_EMIT;
								end
							end
							CMD_TICK: begin
								if (!cfg.enable) begin
									state_q <= ST_EMIT;
								end else if (t_now == '0) begin
									ramp_q <= desired_now;
									if (q_job.now_ms != '0) begin
										last_q <= q_job.now_ms;
									end
									state_q <= ST_EMIT;
								end else begin
									state_q <= ST_MUL;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_MUL: state_q <= ST_SAT;
				ST_SAT: begin
					if (prod_q >= (PROD_W'(t_q) << STEP_W)) begin
						state_q <= ST_APPLY;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					ramp_q <= ramp_next;
					if (now_q != '0) begin
						last_q <= now_q;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				t_q       <= t_now;
				desired_q <= desired_now;
				now_q     <= q_job.now_ms;
				elapsed_q <= (q_job.now_ms != '0) ? (q_job.now_ms - last_q) : '0;
				if (q_job.cmd == CMD_CLEAR) begin
					res_valid_q  <= 1'b1;
					res_drive_q  <= cfg.invert ? DRIVE_W'(DUTY_FULL) :
						DRIVE_W'(min_duty(cfg.bidirectional));
					res_actual_q <= '0;
					res_delay_q  <= DELAY_IDLE;
				end else if (!cfg.enable) begin
					res_valid_q  <= 1'b0;
					res_drive_q  <= '0;
					res_actual_q <= '0;
					res_delay_q  <= DELAY_IDLE;
				end else begin
					res_valid_q  <= 1'b1;
					res_drive_q  <= drive_of(desired_now, cfg.invert);
					res_actual_q <= desired_now;
					res_delay_q  <= DELAY_ACTIVE;
				end
			end
			ST_MUL: begin
				prod_q <= PROD_W'(elapsed_q) * PROD_W'(DUTY_FULL);
				dsh_q  <= PROD_W'(t_q) << (STEP_W - 1);
			end
			ST_SAT: begin
				inc_q <= STEP_W'(MAX_STEP);
				quo_q <= '0;
				cnt_q <= CNT_W'(STEP_W - 1);
			end
			ST_DIV: begin
				if (ge) begin
					prod_q <= prod_q - dsh_q;
				end
				dsh_q <= dsh_q >> 1;
				quo_q <= quo_next;
				cnt_q <= cnt_q - 1'b1;
				inc_q <= (quo_next > STEP_W'(MAX_STEP)) ? STEP_W'(MAX_STEP) : quo_next;
			end
			ST_APPLY: begin
				res_valid_q  <= 1'b1;
				res_drive_q  <= drive_of(ramp_next, cfg.invert);
				res_actual_q <= ramp_next;
				res_delay_q  <= DELAY_ACTIVE;
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_data_q <= M_DATA_W'({res_delay_q, res_actual_q, res_drive_q});
			out_user_q <= res_valid_q;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_user_q;

endmodule

// ===== rtl/core/pwm_duty_soft_ramp_top.sv =====
// pwm duty soft ramp: slew-limited duty output with a command stream in
//
// Items enter on the s_axis channel: tuser carries the command (set,
// clear, tick), tdata the requested duty and the tick time in ms. Results
// leave on the m_axis channel: tuser is drive_valid, tdata holds the
// drive value, the ramp duty and the delay to the next tick.
// Set and unused commands give no result; a clear gives one only when a
// request is held; a tick always gives one.
// Set beats and clears without a held request leave the queue one per
// cycle while the engine is idle; unused commands are never queued. A
// tick with a ramp time goes through MUL, SAT, the restoring divider of
// the step size (one quotient bit per cycle; SAT skips it if the step
// saturates) and APPLY to EMIT; one that jumps or is disabled goes to EMIT.
// A two-entry queue decouples input from the ramp engine, so new beats
// are taken while a result waits in the output register; when the
// receiver stalls the result is held and the queue fills, then s_axis
// tready drops. Reset clears the request, the ramp duty and the last
// tick time and sets enable; no clearing pass is needed.
// Configuration is a write-only register port, index as listed.
`include "pwm_duty_soft_ramp_top_defines.svh"

module pwm_duty_soft_ramp_top
	import psr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [S_DATA_W-1:0]   s_axis_tdata,  // request_duty, now_ms
	input  logic [CMD_W-1:0]      s_axis_tuser,  // cmd
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [M_DATA_W-1:0]   m_axis_tdata,  // drive_value, actual_duty, next_delay_ms
	output logic [0:0]            m_axis_tuser,  // drive_valid
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	logic cfg_drop;
	logic push;
	job_t job_in;
	logic q_full;
	logic q_pop;
	logic q_valid;
	job_t q_job;

	logic [DRIVE_W-1:0]       m_drive;
	logic signed [DUTY_W-1:0] m_duty;
	logic [DELAY_W-1:0]       m_delay;

	assign cfg_drop = cfg_wr_en && (cfg_index == REG_ENABLE) && !cfg_data[0] && cfg_q.enable;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable        <= 1'b1;
			cfg_q.invert        <= 1'b0;
			cfg_q.bidirectional <= 1'b0;
			cfg_q.preset        <= '0;
			cfg_q.custom_ms     <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ENABLE: cfg_q.enable        <= cfg_data[0];
				REG_INVERT: cfg_q.invert        <= cfg_data[0];
				REG_BIDIR:  cfg_q.bidirectional <= cfg_data[0];
				REG_PRESET: cfg_q.preset        <= cfg_data[PRESET_W-1:0];
				REG_CUSTOM: cfg_q.custom_ms     <= cfg_data[CUST_W-1:0];
				default:    cfg_q               <= cfg_q;
			endcase
		end
	end

	psr_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg           (cfg_q),
		.q_full        (q_full),
		.push          (push),
		.job           (job_in)
	);

	psr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (job_in),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.job_out (q_job)
	);

	psr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cfg_drop      (cfg_drop),
		.q_valid       (q_valid),
		.q_job         (q_job),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	assign m_drive = m_axis_tdata[DRIVE_W-1:0];
	assign m_duty  = m_axis_tdata[DRIVE_W +: DUTY_W];
	assign m_delay = m_axis_tdata[DRIVE_W+DUTY_W +: DELAY_W];

	`PSR_ASSERT_IMPL(a_undriven_idle, m_axis_tvalid && !m_axis_tuser[0], m_delay == DELAY_IDLE && m_drive == '0)
	`PSR_ASSERT_IMPL(a_active_delay, m_axis_tvalid && m_delay == DELAY_ACTIVE, m_axis_tuser[0])
	`PSR_ASSERT_ALWAYS(a_duty_range, !m_axis_tvalid || (m_duty >= DUTY_MIN_BI && m_duty <= DUTY_MAX))
	`PSR_ASSERT_IMPL(a_full_after_beat, $fell(s_axis_tready), $past(s_axis_tvalid))

endmodule

// ===== tb/tb_pwm_duty_soft_ramp_top.sv =====
// self-checking testbench of the pwm duty soft ramp block: stream driver, monitor and ramp predictor
`timescale 1ns / 100ps

module tb_pwm_duty_soft_ramp_top;
	import psr_pkg::*;

	localparam logic [CMD_W-1:0]    CMD_UNUSED  = 2'd3;
	localparam logic [PRESET_W-1:0] PRE_OFF     = 3'd0;
	localparam logic [PRESET_W-1:0] PRE_TOP     = 3'd7;
	localparam int                  SETTLE      = 64;
	localparam int                  CYCLE_LIMIT = 600000;

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic                      drive_ok;
		logic signed [DRIVE_W-1:0] drive;
		logic signed [DUTY_W-1:0]  duty;
		logic [DELAY_W-1:0]        delay;
	} drive_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_DATA_W-1:0]   s_axis_tdata = '0;
	logic [CMD_W-1:0]      s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_axis_tdata;
	logic [0:0]            m_axis_tuser;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of the registers and the ramp state
	logic                cfg_en = 1'b1;
	logic                cfg_inv = 1'b0;
	logic                cfg_bidir = 1'b0;
	logic [PRESET_W-1:0] cfg_preset = PRE_OFF;
	logic [CUST_W-1:0]   cfg_custom = '0;
	int                  req_held = 0;
	bit                  req_present = 1'b0;
	int                  ramp = 0;
	logic [TIME_W-1:0]   last_tick = '0;

	job_t   beats_to_send[$];
	drive_t drives_due[$];
	job_t   cur_beat;
	bit     offering = 1'b0;
	bit     hold_for_drain = 1'b0;
	int     send_idle_pct = 0;
	int     recv_idle_pct = 0;
	int     fails = 0;
	int     cycles = 0;
	logic [TIME_W-1:0] clock_ms = '0;

	pwm_duty_soft_ramp_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, drives_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic bit advance_ramp(input job_t beat, output drive_t res);
		int lo;
		int want;
		int t;
		int step;
		logic [TIME_W-1:0] elapsed;
		u64_t raw;
		lo = cfg_bidir ? -DUTY_FULL : 0;
		res = '0;
		case (beat.cmd)
			CMD_SET: begin
				want = int'(beat.duty);
				if (want < lo)
					want = lo;
				if (want > DUTY_FULL)
					want = DUTY_FULL;
				req_held = want;
				req_present = 1'b1;
				return 1'b0;
			end
			CMD_CLEAR: begin
				if (!req_present)
					return 1'b0;
				res.drive_ok = 1'b1;
				res.drive = DRIVE_W'(cfg_inv ? DUTY_FULL : lo);
				res.duty = '0;
				res.delay = DELAY_IDLE;
				req_present = 1'b0;
				req_held = 0;
				return 1'b1;
			end
			CMD_TICK: begin
				if (!cfg_en) begin
					res.delay = DELAY_IDLE;
					return 1'b1;
				end
				want = req_present ? req_held : 0;
				case (cfg_preset)
					PRE_SHORT:  t = 250;
					PRE_MID:    t = 750;
					PRE_LONG:   t = 2000;
					PRE_CUSTOM: t = int'(cfg_custom);
					default:    t = 0;
				endcase
				if (t != 0) begin
					elapsed = (beat.now_ms != '0) ? beat.now_ms - last_tick : '0;
					raw = u64_t'(DUTY_FULL) * u64_t'(elapsed) / u64_t'(t);
					step = (raw > u64_t'(MAX_STEP)) ? MAX_STEP : int'(raw);
					if (ramp < want) begin
						ramp += step;
						if (ramp > want)
							ramp = want;
					end else if (ramp > want) begin
						ramp -= step;
						if (ramp < want)
							ramp = want;
					end
					if (want > 0 && ramp == 0)
						ramp = 1;
				end else begin
					ramp = want;
				end
				res.drive_ok = 1'b1;
				res.drive = DRIVE_W'(cfg_inv ? DUTY_FULL - ramp : ramp);
				res.duty = DUTY_W'(ramp);
				res.delay = DELAY_ACTIVE;
				if (beat.now_ms != '0)
					last_tick = beat.now_ms;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// driver: one beat at a time from the pending queue
	always @(posedge clk) begin : drive_beats
		drive_t res;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				offering = 1'b0;
				if (advance_ramp(cur_beat, res))
					drives_due.push_back(res);
			end
			if (hold_for_drain && drives_due.size() == 0)
				hold_for_drain = 1'b0;
			if (!offering && !hold_for_drain && beats_to_send.size() != 0
			    && drives_due.size() != 0 && $urandom_range(0, 249) == 0)
				hold_for_drain = 1'b1;
			if (!offering && !hold_for_drain && beats_to_send.size() != 0
			    && $urandom_range(0, 99) >= send_idle_pct) begin
				cur_beat = beats_to_send.pop_front();
				offering = 1'b1;
				s_axis_tdata <= {{(S_DATA_W - DUTY_W - TIME_W){1'b0}}, cur_beat.now_ms,
					cur_beat.duty};
				s_axis_tuser <= cur_beat.cmd;
			end
			s_axis_tvalid <= offering;
		end
	end

	// monitor: every result beat against the oldest expected drive
	always @(posedge clk) begin : check_drives
		drive_t got;
		drive_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.drive_ok = m_axis_tuser[0];
				got.drive = m_axis_tdata[DRIVE_W-1:0];
				got.duty = m_axis_tdata[DRIVE_W +: DUTY_W];
				got.delay = m_axis_tdata[DRIVE_W + DUTY_W +: DELAY_W];
				if (drives_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result: valid %0b drive %0d duty %0d delay %0d",
							got.drive_ok, got.drive, got.duty, got.delay);
				end else begin
					want = drives_due.pop_front();
					if (got !== want) begin
						fails++;
						if (fails <= 10)
							$display({"mismatch: valid %0b/%0b drive %0d/%0d duty %0d/%0d ",
								"delay %0d/%0d (expected/actual)"},
								want.drive_ok, got.drive_ok, want.drive, got.drive,
								want.duty, got.duty, want.delay, got.delay);
					end
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	function automatic void queue_beat(input logic [CMD_W-1:0] c, input int d,
		input logic [TIME_W-1:0] stamp);
		job_t b;
		b.cmd = c;
		b.duty = d[DUTY_W-1:0];
		b.now_ms = stamp;
		beats_to_send.push_back(b);
	endfunction

	task automatic wait_idle();
		while (beats_to_send.size() != 0 || offering || drives_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_ENABLE: begin
				if (!val[0] && cfg_en) begin
					req_present = 1'b0;
					req_held = 0;
				end
				cfg_en = val[0];
			end
			REG_INVERT: cfg_inv = val[0];
			REG_BIDIR:  cfg_bidir = val[0];
			REG_PRESET: cfg_preset = val[PRESET_W-1:0];
			REG_CUSTOM: cfg_custom = val[CUST_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic en, input logic inv, input logic bi,
		input logic [PRESET_W-1:0] preset, input logic [CUST_W-1:0] custom);
		wait_idle();
		write_reg(REG_ENABLE, CFG_DATA_W'(en));
		write_reg(REG_INVERT, CFG_DATA_W'(inv));
		write_reg(REG_BIDIR, CFG_DATA_W'(bi));
		write_reg(REG_PRESET, CFG_DATA_W'(preset));
		write_reg(REG_CUSTOM, CFG_DATA_W'(custom));
	endtask

	task automatic queue_random(input int n);
		int pick;
		int r;
		int duty;
		logic [TIME_W-1:0] stamp;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				r = $urandom_range(0, 99);
				if (r < 80) begin
					clock_ms += $urandom_range(1, 30);
					stamp = clock_ms;
				end else if (r < 88) begin
					clock_ms += $urandom_range(31, 5000);
					stamp = clock_ms;
				end else if (r < 93) begin
					clock_ms = $urandom();
					stamp = clock_ms;
				end else if (r < 96) begin
					stamp = '0;
				end else begin
					// just below the wrap of the millisecond counter
					clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
					stamp = clock_ms;
				end
				queue_beat(CMD_TICK, $urandom(), stamp);
			end else if (pick < 84) begin
				if ($urandom_range(0, 1))
					duty = $urandom_range(0, 8191);
				else
					duty = int'($urandom_range(0, 600)) - 300;
				queue_beat(CMD_SET, duty, $urandom());
			end else if (pick < 96) begin
				queue_beat(CMD_CLEAR, $urandom(), $urandom());
			end else begin
				queue_beat(CMD_UNUSED, $urandom(), $urandom());
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: jump mode, unipolar, not inverted
		send_idle_pct = 19;
		recv_idle_pct = 82;
		queue_beat(CMD_TICK, 0, 32'd0);
		queue_beat(CMD_CLEAR, 0, 32'd0);
		queue_beat(CMD_UNUSED, -1, 32'hFFFF_FFFF);
		queue_beat(CMD_SET, DUTY_FULL, 32'd0);
		queue_beat(CMD_TICK, 0, 32'd10);
		queue_beat(CMD_SET, -4096, 32'd0);
		queue_beat(CMD_TICK, 0, 32'd20);
		queue_beat(CMD_CLEAR, 0, 32'd0);

		// bipolar inverted short ramp: cap, unknown time, wrap
		set_config(1'b1, 1'b1, 1'b1, PRE_SHORT, '0);
		queue_beat(CMD_SET, -DUTY_FULL, 32'd0);
		queue_beat(CMD_TICK, 0, 32'd1000);
		queue_beat(CMD_TICK, 0, 32'd1010);
		queue_beat(CMD_TICK, 0, 32'd0);
		queue_beat(CMD_TICK, 0, 32'hFFFF_FFF0);
		queue_beat(CMD_TICK, 0, 32'd5);
		queue_beat(CMD_SET, DUTY_FULL, 32'd0);
		queue_beat(CMD_TICK, 0, 32'd15);
		queue_beat(CMD_CLEAR, 0, 32'd0);
		queue_beat(CMD_SET, -2000, 32'd0);

		// held negative request survives the switch to unipolar
		set_config(1'b1, 1'b0, 1'b0, PRE_OFF, '0);
		queue_beat(CMD_TICK, 0, 32'd25);
		queue_beat(CMD_CLEAR, 0, 32'd0);
		queue_beat(CMD_TICK, 0, 32'd30);

		// longest custom ramp: minimum one lsb, step overflow
		set_config(1'b1, 1'b0, 1'b0, PRE_CUSTOM, 22'd3600000);
		queue_beat(CMD_SET, 1, 32'd0);
		queue_beat(CMD_TICK, 0, 32'd40);
		queue_beat(CMD_SET, DUTY_FULL, 32'd0);
		queue_beat(CMD_TICK, 0, 32'h7FFF_FFFF);

		// disable drops the request
		wait_idle();
		write_reg(REG_ENABLE, '0);
		queue_beat(CMD_TICK, 0, 32'h8000_0100);
		queue_beat(CMD_CLEAR, 0, 32'd0);
		wait_idle();
		// indexes past the register list are ignored
		for (int r = int'(REG_CUSTOM) + 1; r < (1 << CFG_IDX_W); r++)
			write_reg(CFG_IDX_W'(r), '1);
		write_reg(REG_ENABLE, CFG_DATA_W'(1));
		queue_beat(CMD_TICK, 0, 32'h8000_0200);

		clock_ms = 32'h8000_0200;
		for (int p = 0; p < 9; p++) begin
			case (p)
				0: set_config(1'b1, 1'b0, 1'b0, PRE_SHORT, CUST_W'($urandom_range(0, 3600000)));
				1: set_config(1'b1, 1'b1, 1'b1, PRE_LONG, CUST_W'($urandom_range(0, 3600000)));
				2: set_config(1'b1, 1'b0, 1'b1, PRE_CUSTOM, 22'd3600000);
				3: set_config(1'b1, 1'b1, 1'b0, PRE_CUSTOM, 22'd1);
				4: set_config(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), PRE_MID,
					CUST_W'($urandom_range(0, 3600000)));
				5: set_config(1'b1, 1'b0, 1'b1, PRE_CUSTOM, '0);
				6: set_config(1'b1, 1'b1, 1'($urandom_range(0, 1)),
					PRESET_W'($urandom_range(PRE_CUSTOM + 1, PRE_TOP)),
					CUST_W'($urandom_range(0, 3600000)));
				7: set_config(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					PRE_CUSTOM, CUST_W'($urandom_range(1, 3000)));
				default: set_config(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					PRE_MID, CUST_W'($urandom_range(0, 3600000)));
			endcase
			case (p / 3)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 19;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			queue_random(150);
		end

		wait_idle();
		if (fails == 0 && drives_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
